// File: hdl/clad_pkg.sv
// ----------------------------------------------------------------------------
// clad_pkg
// Types and codes shared by the circular list block and its interfaces.
// ----------------------------------------------------------------------------
package clad_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned OpWidth     = 2;
  localparam int unsigned StatusWidth = 3;

  typedef enum logic [OpWidth-1:0] {
    OP_APPEND   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TRAVERSE = 2'd2
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_TAIL,
    S_A_SCAN,
    S_A_WRITE,
    S_A_LINK,
    S_D_CMP,
    S_D_UNLINK,
    S_T_OUT,
    S_EMIT
  } state_e;

endpackage

// File: hdl/clad_if.sv
// ----------------------------------------------------------------------------
// clad_if
// Request and result channels of the circular list block (valid/ready).
// ----------------------------------------------------------------------------
interface clad_req_if;
  logic                                      valid;
  logic                                      ready;
  logic        [clad_pkg::OpWidth-1:0]       operation;
  logic signed [clad_pkg::ValueWidth-1:0]    value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface clad_rsp_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [clad_pkg::ValueWidth-1:0]    item_value;
  logic        [clad_pkg::StatusWidth-1:0]   status;
  logic                                      last_of_run;

  modport source (output valid, output item_value, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input item_value, input status, input last_of_run,
                  output ready);
endinterface

// File: hdl/clad_ram.sv
// ----------------------------------------------------------------------------
// clad_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module clad_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 64,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Read data holds while no read is issued.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/circular_list_append_delete.sv
// ----------------------------------------------------------------------------
// circular_list_append_delete
// Circular doubly linked list of signed 32-bit values kept in on-chip RAMs.
// ----------------------------------------------------------------------------
// Requests arrive on req_i (operation, value) and results leave on rsp_o
// (item_value, status, last_of_run); both use valid/ready and a transfer
// happens when both are high. Append puts the value at the tail, delete removes
// the first equal value found from the head, traverse emits every value from
// the head with last_of_run on the final one. Every request except the unused
// operation code gives at least one result, and its last result has
// last_of_run set.
// One request is worked on at a time; ready is high only while the block is
// idle. Append reads the tail, scans the used map from entry 0 for the lowest
// free one, writes the new entry and then links it in; on a full list it goes
// straight to the result. Delete walks one linked entry per cycle through the
// value and link RAMs. Traverse emits one value per cycle from the RAM read
// port while the receiver takes them, DEPTH results at most.
// The result sits in an output register, so a stalled receiver holds only the
// walk step that needs to hand over a value; a traverse resumes where it
// stopped. Reset empties the list at once: the used map and the count are
// flip-flops, and the RAM contents need no clearing.
// ----------------------------------------------------------------------------
module circular_list_append_delete #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  clad_req_if.sink    req_i,
  clad_rsp_if.source  rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = clad_pkg::ValueWidth;

  clad_pkg::state_e  state_q, state_d;

  logic [AW-1:0]     head_q;
  logic [CW-1:0]     count_q;
  logic [DEPTH-1:0]  used_q;

  logic [VW-1:0]     req_val_q;
  clad_pkg::status_e emit_st_q;
  logic [AW-1:0]     cur_q, scan_q, slot_q, tail_q, nx_q, pv_q;
  logic [CW-1:0]     n_q;

  logic                       out_valid_q;
  logic [VW-1:0]              out_val_q;
  clad_pkg::status_e          out_st_q;
  logic                       out_last_q;

  // RAM ports.
  logic          val_we, nxt_we, prv_we, rd_en;
  logic [AW-1:0] val_waddr, nxt_waddr, prv_waddr, rd_addr;
  logic [VW-1:0] val_wdata, val_rdata;
  logic [AW-1:0] nxt_wdata, prv_wdata, nxt_rdata, prv_rdata;

  logic              req_fire, out_free, out_load, match, walk_last;
  logic              cnt_empty, cnt_full, cnt_one;
  logic [CW-1:0]     n_inc;
  logic [VW-1:0]     out_val_d;
  clad_pkg::status_e out_st_d;
  logic              out_last_d;
  clad_pkg::op_e     req_op;

  assign req_i.ready = (state_q == clad_pkg::S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign req_op      = clad_pkg::op_e'(req_i.operation);
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign match       = (val_rdata == req_val_q);
  assign cnt_empty   = (count_q == '0);
  assign cnt_full    = (count_q == CW'(DEPTH));
  assign cnt_one     = (count_q == CW'(1));
  assign n_inc       = n_q + CW'(1);
  assign walk_last   = (n_inc == count_q);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      clad_pkg::S_IDLE: begin
        if (req_fire) begin
          unique case (req_op)
            clad_pkg::OP_APPEND:   state_d = cnt_full  ? clad_pkg::S_EMIT : clad_pkg::S_A_TAIL;
            clad_pkg::OP_DELETE:   state_d = cnt_empty ? clad_pkg::S_EMIT : clad_pkg::S_D_CMP;
            clad_pkg::OP_TRAVERSE: state_d = cnt_empty ? clad_pkg::S_EMIT : clad_pkg::S_T_OUT;
            default:               state_d = clad_pkg::S_IDLE;
          endcase
        end
      end
      clad_pkg::S_A_TAIL:  state_d = clad_pkg::S_A_SCAN;
      clad_pkg::S_A_SCAN: begin
        if (!used_q[scan_q]) begin
          state_d = clad_pkg::S_A_WRITE;
        end
      end
      clad_pkg::S_A_WRITE: state_d = clad_pkg::S_A_LINK;
      clad_pkg::S_A_LINK:  state_d = clad_pkg::S_EMIT;
      clad_pkg::S_D_CMP: begin
        if (match) begin
          state_d = cnt_one ? clad_pkg::S_EMIT : clad_pkg::S_D_UNLINK;
        end else if (walk_last) begin
          state_d = clad_pkg::S_EMIT;
        end
      end
      clad_pkg::S_D_UNLINK: state_d = clad_pkg::S_EMIT;
      clad_pkg::S_T_OUT: begin
        if (out_free && walk_last) begin
          state_d = clad_pkg::S_IDLE;
        end
      end
      clad_pkg::S_EMIT: begin
        if (out_free) begin
          state_d = clad_pkg::S_IDLE;
        end
      end
      default: state_d = clad_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs: RAM accesses and result load. Reads and writes never meet in one
  // cycle, and each write lands before the next read of any entry, so no
  // forwarding is needed.
  // --------------------------------------------------------------------------
  always_comb begin
    val_we     = 1'b0;
    nxt_we     = 1'b0;
    prv_we     = 1'b0;
    val_waddr  = slot_q;
    nxt_waddr  = slot_q;
    prv_waddr  = slot_q;
    val_wdata  = req_val_q;
    nxt_wdata  = head_q;
    prv_wdata  = tail_q;
    rd_en      = 1'b0;
    rd_addr    = head_q;
    out_load   = 1'b0;
    out_val_d  = req_val_q;
    out_st_d   = emit_st_q;
    out_last_d = 1'b1;
    unique case (state_q)
      clad_pkg::S_IDLE: begin
        rd_en = req_fire;
      end
      clad_pkg::S_A_WRITE: begin
        val_we = 1'b1;
        nxt_we = 1'b1;
        prv_we = 1'b1;
        if (cnt_empty) begin
          nxt_wdata = slot_q;
          prv_wdata = slot_q;
        end
      end
      clad_pkg::S_A_LINK: begin
        nxt_we    = !cnt_empty;
        prv_we    = !cnt_empty;
        nxt_waddr = tail_q;
        nxt_wdata = slot_q;
        prv_waddr = head_q;
        prv_wdata = slot_q;
      end
      clad_pkg::S_D_CMP: begin
        rd_en   = !match && !walk_last;
        rd_addr = nxt_rdata;
      end
      clad_pkg::S_D_UNLINK: begin
        nxt_we    = 1'b1;
        prv_we    = 1'b1;
        nxt_waddr = pv_q;
        nxt_wdata = nx_q;
        prv_waddr = nx_q;
        prv_wdata = pv_q;
      end
      clad_pkg::S_T_OUT: begin
        rd_en      = out_free && !walk_last;
        rd_addr    = nxt_rdata;
        out_load   = out_free;
        out_val_d  = val_rdata;
        out_st_d   = clad_pkg::ST_OK;
        out_last_d = walk_last;
      end
      clad_pkg::S_EMIT: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  clad_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  clad_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_nxt_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (nxt_rdata)
  );

  clad_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_prv_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (prv_rdata)
  );

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= clad_pkg::S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == clad_pkg::S_A_LINK) begin
        used_q[slot_q] <= 1'b1;
        count_q        <= count_q + CW'(1);
        if (cnt_empty) begin
          head_q <= slot_q;
        end
      end
      if (state_q == clad_pkg::S_D_CMP && match) begin
        used_q[cur_q] <= 1'b0;
        count_q       <= count_q - CW'(1);
      end
      if (state_q == clad_pkg::S_D_UNLINK && cur_q == head_q) begin
        head_q <= nx_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q  <= out_val_d;
      out_st_q   <= out_st_d;
      out_last_q <= out_last_d;
    end
    unique case (state_q)
      clad_pkg::S_IDLE: begin
        if (req_fire) begin
          req_val_q <= req_i.value;
          cur_q     <= head_q;
          n_q       <= '0;
          scan_q    <= '0;
          emit_st_q <= (req_op == clad_pkg::OP_APPEND) ? clad_pkg::ST_FULL
                                                       : clad_pkg::ST_EMPTY;
        end
      end
      clad_pkg::S_A_TAIL: begin
        tail_q <= prv_rdata;
      end
      clad_pkg::S_A_SCAN: begin
        if (used_q[scan_q]) begin
          scan_q <= scan_q + AW'(1);
        end else begin
          slot_q <= scan_q;
        end
      end
      clad_pkg::S_A_LINK: begin
        emit_st_q <= clad_pkg::ST_OK;
      end
      clad_pkg::S_D_CMP: begin
        if (match) begin
          nx_q      <= nxt_rdata;
          pv_q      <= prv_rdata;
          emit_st_q <= clad_pkg::ST_REMOVED;
        end else if (walk_last) begin
          emit_st_q <= clad_pkg::ST_NOT_FOUND;
        end else begin
          cur_q <= nxt_rdata;
          n_q   <= n_inc;
        end
      end
      clad_pkg::S_T_OUT: begin
        if (out_free && !walk_last) begin
          n_q <= n_inc;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.item_value  = $signed(out_val_q);
  assign rsp_o.status      = out_st_q;
  assign rsp_o.last_of_run = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above DEPTH");

  a_used_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == int'(count_q))
    else $error("used map disagrees with entry count");

  a_scan_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == clad_pkg::S_A_SCAN |-> !cnt_full)
    else $error("free entry search on a full list");

  a_unlink_leaves_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == clad_pkg::S_D_UNLINK |-> !cnt_empty)
    else $error("unlink with no entries left");

endmodule

// File: test/circular_list_append_delete_test.sv
// ----------------------------------------------------------------------------
// circular_list_append_delete_test
// Self-checking bench for the circular list: a short table of requests with
// typed-in results where they are obvious, then random traffic of all four
// operation codes, checked against a shadow copy of the list kept here.
// ----------------------------------------------------------------------------
module circular_list_append_delete_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam logic [clad_pkg::OpWidth-1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [clad_pkg::ValueWidth-1:0]  item_value;
    logic [clad_pkg::StatusWidth-1:0] status;
    logic                             last_of_run;
  } list_result_t;

  // A request either carries a typed-in status or leaves the result to the
  // shadow list.
  typedef struct {
    bit                given;
    clad_pkg::status_e status;
  } status_note_t;

  typedef struct {
    logic [clad_pkg::OpWidth-1:0]    op;
    logic [clad_pkg::ValueWidth-1:0] val;
    bit                              given;
    clad_pkg::status_e               status;
  } directed_row_t;

  logic clk;
  logic rst_n;

  clad_req_if req ();
  clad_rsp_if rsp ();

  circular_list_append_delete #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  // Shadow copy of the list.
  logic [clad_pkg::ValueWidth-1:0] list_value [DEPTH];
  int                              list_next  [DEPTH];
  int                              list_prev  [DEPTH];
  bit                              list_used  [DEPTH];
  int                              list_head  = 0;
  int                              list_count = 0;

  list_result_t                    pending_results [$];
  status_note_t                    status_notes [$];
  logic [clad_pkg::ValueWidth-1:0] appended_values [$];
  int                              failures = 0;
  bit                              no_idle = 1'b0;

  directed_row_t directed_rows [23] = '{
    '{clad_pkg::OP_TRAVERSE, 32'h1234_5678, 1'b1, clad_pkg::ST_EMPTY},
    '{clad_pkg::OP_DELETE,   32'h8000_0000, 1'b1, clad_pkg::ST_EMPTY},
    '{clad_pkg::OP_APPEND,   32'h7fff_ffff, 1'b1, clad_pkg::ST_OK},
    '{clad_pkg::OP_APPEND,   32'h8000_0000, 1'b1, clad_pkg::ST_OK},
    '{clad_pkg::OP_APPEND,   32'h0000_0000, 1'b1, clad_pkg::ST_OK},
    '{clad_pkg::OP_APPEND,   32'hffff_ffff, 1'b1, clad_pkg::ST_OK},
    '{clad_pkg::OP_TRAVERSE, 32'h0000_0000, 1'b0, clad_pkg::ST_OK},
    '{clad_pkg::OP_DELETE,   32'h0000_0005, 1'b1, clad_pkg::ST_NOT_FOUND},
    '{clad_pkg::OP_DELETE,   32'h8000_0000, 1'b1, clad_pkg::ST_REMOVED},
    '{clad_pkg::OP_DELETE,   32'h7fff_ffff, 1'b1, clad_pkg::ST_REMOVED},
    '{OpUnused,              32'hdead_beef, 1'b0, clad_pkg::ST_OK},
    '{clad_pkg::OP_APPEND,   32'h7fff_ffff, 1'b1, clad_pkg::ST_OK},
    '{clad_pkg::OP_TRAVERSE, 32'hffff_ffff, 1'b0, clad_pkg::ST_OK},
    '{clad_pkg::OP_DELETE,   32'h0000_0000, 1'b1, clad_pkg::ST_REMOVED},
    '{clad_pkg::OP_DELETE,   32'hffff_ffff, 1'b1, clad_pkg::ST_REMOVED},
    '{clad_pkg::OP_DELETE,   32'h7fff_ffff, 1'b1, clad_pkg::ST_REMOVED},
    '{clad_pkg::OP_TRAVERSE, 32'h0000_cafe, 1'b1, clad_pkg::ST_EMPTY},
    '{clad_pkg::OP_APPEND,   32'h5555_5555, 1'b1, clad_pkg::ST_OK},
    '{clad_pkg::OP_APPEND,   32'haaaa_aaaa, 1'b1, clad_pkg::ST_OK},
    '{clad_pkg::OP_APPEND,   32'h5555_5555, 1'b1, clad_pkg::ST_OK},
    '{clad_pkg::OP_DELETE,   32'h5555_5555, 1'b1, clad_pkg::ST_REMOVED},
    '{clad_pkg::OP_TRAVERSE, 32'h0000_0000, 1'b0, clad_pkg::ST_OK},
    '{OpUnused,              32'hffff_ffff, 1'b0, clad_pkg::ST_OK}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  // Applies one accepted request to the shadow list and queues its results.
  function automatic void apply_list_request(input logic [clad_pkg::OpWidth-1:0] op,
                                             input logic [clad_pkg::ValueWidth-1:0] val,
                                             input status_note_t note);
    list_result_t results [$];
    int slot, cur, nx, pv, tail, n;
    bit found;
    slot = -1;
    found = 1'b0;
    case (op)
      clad_pkg::OP_APPEND: begin
        if (list_count < DEPTH) begin
          for (n = DEPTH - 1; n >= 0; n--) begin
            if (!list_used[n]) slot = n;
          end
        end
        if (slot < 0) begin
          results.push_back('{val, clad_pkg::ST_FULL, 1'b1});
        end else begin
          list_value[slot] = val;
          list_used[slot] = 1'b1;
          if (list_count == 0) begin
            list_next[slot] = slot;
            list_prev[slot] = slot;
            list_head = slot;
          end else begin
            tail = list_prev[list_head];
            list_next[slot] = list_head;
            list_prev[slot] = tail;
            list_next[tail] = slot;
            list_prev[list_head] = slot;
          end
          list_count++;
          results.push_back('{val, clad_pkg::ST_OK, 1'b1});
        end
      end
      clad_pkg::OP_DELETE: begin
        if (list_count == 0) begin
          results.push_back('{val, clad_pkg::ST_EMPTY, 1'b1});
        end else begin
          cur = list_head;
          for (n = 0; n < list_count && !found; n++) begin
            if (list_value[cur] == val) found = 1'b1;
            else cur = list_next[cur];
          end
          if (!found) begin
            results.push_back('{val, clad_pkg::ST_NOT_FOUND, 1'b1});
          end else begin
            if (list_count > 1) begin
              nx = list_next[cur];
              pv = list_prev[cur];
              list_next[pv] = nx;
              list_prev[nx] = pv;
              if (cur == list_head) list_head = nx;
            end
            list_used[cur] = 1'b0;
            list_count--;
            results.push_back('{val, clad_pkg::ST_REMOVED, 1'b1});
          end
        end
      end
      clad_pkg::OP_TRAVERSE: begin
        if (list_count == 0) begin
          results.push_back('{val, clad_pkg::ST_EMPTY, 1'b1});
        end else begin
          cur = list_head;
          for (n = 0; n < list_count; n++) begin
            results.push_back('{list_value[cur], clad_pkg::ST_OK, n == list_count - 1});
            cur = list_next[cur];
          end
        end
      end
      default: ;
    endcase
    if (note.given) pending_results.push_back('{val, note.status, 1'b1});
    else foreach (results[i]) pending_results.push_back(results[i]);
  endfunction

  always @(posedge clk) begin
    if (req.valid && req.ready) begin
      apply_list_request(req.operation, req.value, status_notes.pop_front());
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: item_value %0d status %0d last_of_run %0b",
               rsp.item_value, rsp.status, rsp.last_of_run);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (rsp.item_value !== want.item_value) begin
          $error("item_value: expected %0d, got %0d", $signed(want.item_value),
                 rsp.item_value);
          failures++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          failures++;
        end
        if (rsp.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run, rsp.last_of_run);
          failures++;
        end
      end
    end
  end

  // Result side: holds ready low for a random stall before each result.
  initial begin
    int stall;
    rsp.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  // Called at a rising edge; returns at the edge that accepts the request.
  task automatic send_request(input logic [clad_pkg::OpWidth-1:0] op,
                              input logic [clad_pkg::ValueWidth-1:0] val,
                              input bit given, input clad_pkg::status_e status);
    int gap;
    status_note_t note;
    gap = draw_wait();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    note.given = given;
    note.status = status;
    status_notes.push_back(note);
    if (op == clad_pkg::OP_APPEND) begin
      appended_values.push_back(val);
      if (appended_values.size() > DEPTH) void'(appended_values.pop_front());
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.value <= val;
    do @(posedge clk); while (!req.ready);
  endtask

  // Small values repeat often, which gives duplicates in the list.
  function automatic logic [clad_pkg::ValueWidth-1:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1: return $urandom_range(0, 7);
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [clad_pkg::ValueWidth-1:0] pick_search_value();
    if (appended_values.size() > 0 && $urandom_range(0, 3) != 0) begin
      return appended_values[$urandom_range(0, appended_values.size() - 1)];
    end
    return pick_value();
  endfunction

  task automatic run_mix(input int count, input int append_w, input int delete_w,
                         input int traverse_w);
    int i, r;
    for (i = 0; i < count; i++) begin
      // Now and then a stretch where neither side idles.
      if (i % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, append_w + delete_w + traverse_w);
      if (r < append_w) begin
        send_request(clad_pkg::OP_APPEND, pick_value(), 1'b0, clad_pkg::ST_OK);
      end else if (r < append_w + delete_w) begin
        send_request(clad_pkg::OP_DELETE, pick_search_value(), 1'b0, clad_pkg::ST_OK);
      end else if (r < append_w + delete_w + traverse_w) begin
        send_request(clad_pkg::OP_TRAVERSE, $urandom, 1'b0, clad_pkg::ST_OK);
      end else begin
        send_request(OpUnused, $urandom, 1'b0, clad_pkg::ST_OK);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int i;
    rst_n <= 1'b0;
    req.valid <= 1'b0;
    req.operation <= clad_pkg::OP_APPEND;
    req.value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      send_request(directed_rows[k].op, directed_rows[k].val, directed_rows[k].given,
                   directed_rows[k].status);
    end

    run_mix(30, 10, 6, 3);
    // Fill the list to the top, run into the full case, then walk it whole.
    for (i = 0; i < DEPTH + 2; i++) begin
      send_request(clad_pkg::OP_APPEND, pick_value(), 1'b0, clad_pkg::ST_OK);
    end
    send_request(clad_pkg::OP_TRAVERSE, $urandom, 1'b0, clad_pkg::ST_OK);
    run_mix(35, 2, 12, 3);
    run_mix(15, 8, 8, 3);
    req.valid <= 1'b0;

    @(posedge clk);
    while (pending_results.size() != 0 || status_notes.size() != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);

    if (failures == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
